// File: rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the load cell ADC serial reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam int LCR_COUNT_BITS = 24;
    localparam int LCR_EXTRA_MAX  = 4;
    localparam int LCR_SHIFT_W    = LCR_COUNT_BITS + LCR_EXTRA_MAX;
    localparam int LCR_GAIN_W     = 3;
    localparam int LCR_POLL_W     = 32;
    localparam int LCR_TIMER_W    = LCR_POLL_W + 3;
    localparam int LCR_PULSE_W    = 16;
    localparam int LCR_BITCNT_W   = 5;
    localparam int LCR_OVF_W      = 16;
    localparam int LCR_WORD_W     = 32;
    localparam int LCR_CFG_IDX_W  = 2;
    localparam int LCR_CFG_DATA_W = 32;

    localparam logic [LCR_GAIN_W-1:0]   GAIN_MIN      = 3'd1;
    localparam logic [LCR_GAIN_W-1:0]   GAIN_MAX      = 3'd4;
    localparam logic [LCR_GAIN_W-1:0]   GAIN_RESET    = 3'd1;
    localparam logic [LCR_PULSE_W-1:0]  PULSE_RESET   = 16'd20;
    localparam logic [LCR_BITCNT_W-1:0] BITCNT_MAX    = 5'd31;
    localparam logic [LCR_OVF_W-1:0]    OVF_SAT       = '1;
    localparam logic [LCR_WORD_W-1:0]   WORD_DESYNC   = 32'h8000_0000;
    localparam logic [LCR_WORD_W-1:0]   WORD_TOO_LONG = 32'h4000_0000;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DESYNC   = 2'd1,
        ERR_TOO_LONG = 2'd2
    } t_err;

    typedef enum logic [LCR_CFG_IDX_W-1:0] {
        REG_GAIN  = 2'd0,
        REG_POLL  = 2'd1,
        REG_PULSE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [LCR_OVF_W-1:0]  overflow_count;
        logic                  data_ready;
        logic [LCR_WORD_W-1:0] sample_word;
        logic                  sample_valid;
        logic                  sclk_level;
    } t_result;

    localparam int LCR_RES_W = $bits(t_result);

endpackage

// File: rtl/load_cell_adc_serial_reader_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_top
// Load cell ADC serial reader: one input transaction per pin tick.
//
//   port group   dir  payload
//   s_axis_*     in   tdata[0] dout_level
//   m_axis_*     out  sclk_level, sample_valid, sample_word, data_ready,
//                     overflow_count
//   i_cfg_*      in   0 gain_select, 1 poll_interval, 2 pulse_ticks
//
// One transaction per cycle while s_axis_tready is high; each input transaction
// yields one output transaction, registered in the output or skid register.
// A two-entry output buffer (output register plus skid register) keeps input
// accepted while one result waits; s_axis_tready drops only when both hold.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] dout_level
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] sclk_level, [1] sample_valid, [33:2] sample_word, [34] data_ready,
    // [50:35] overflow_count
    output logic [55:0]                         m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [lcr_pkg::LCR_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lcr_pkg::LCR_CFG_DATA_W-1:0]  i_cfg_data
);

    logic             accept;
    logic             pop;
    lcr_pkg::t_result res;
    lcr_pkg::t_result r_out_data;
    lcr_pkg::t_result r_skid_data;
    logic             r_out_valid;
    logic             r_skid_valid;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    lcr_step_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_dout      (s_axis_tdata[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : res;
        end
        if (accept && r_out_valid && !pop) begin
            r_skid_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(56 - lcr_pkg::LCR_RES_W)'(0), r_out_data};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && r_out_data == $past(r_out_data)))
        else $error("stalled output transaction changed");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> r_skid_valid)
        else $error("buffered transaction dropped");

endmodule

// File: rtl/lcr_step_core.sv
// ----------------------------------------------------------------------------
// lcr_step_core
// Per-tick state update: poll timer, serial read sequencer, error tracking.
// ----------------------------------------------------------------------------
module lcr_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_dout,
    input  logic                                i_cfg_we,
    input  logic [lcr_pkg::LCR_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lcr_pkg::LCR_CFG_DATA_W-1:0]  i_cfg_data,
    output lcr_pkg::t_result                    o_res
);

    logic [lcr_pkg::LCR_GAIN_W-1:0]   r_gain;
    logic [lcr_pkg::LCR_POLL_W-1:0]   r_poll;
    logic [lcr_pkg::LCR_PULSE_W-1:0]  r_pulse;

    logic [lcr_pkg::LCR_TIMER_W-1:0]  r_timer,   n_timer;
    logic                             r_pending, n_pending;
    logic                             r_ovf_flag, n_ovf_flag;
    logic [lcr_pkg::LCR_BITCNT_W-1:0] r_bitcnt,  n_bitcnt;
    logic [lcr_pkg::LCR_SHIFT_W-1:0]  r_shift,   n_shift;
    logic [lcr_pkg::LCR_PULSE_W-1:0]  r_ptimer,  n_ptimer;
    logic                             r_phase,   n_phase;
    lcr_pkg::t_err                    r_err,     n_err;
    logic [lcr_pkg::LCR_OVF_W-1:0]    r_ovf_tot, n_ovf_tot;

    logic [lcr_pkg::LCR_GAIN_W-1:0]       gain_eff;
    logic [lcr_pkg::LCR_BITCNT_W-1:0]     bit_total;
    logic [lcr_pkg::LCR_PULSE_W-1:0]      phase_len;
    logic [lcr_pkg::LCR_EXTRA_MAX:0]      extra_wide;
    logic [lcr_pkg::LCR_EXTRA_MAX-1:0]    extra_mask;
    logic [lcr_pkg::LCR_COUNT_BITS-1:0]   counts;
    logic [lcr_pkg::LCR_WORD_W-1:0]       counts_ext;
    logic [lcr_pkg::LCR_TIMER_W-1:0]      timer_dec;
    logic                                 cfg_poll_wr;
    lcr_pkg::t_result                     res;

    always_comb begin
        if (r_gain < lcr_pkg::GAIN_MIN) begin
            gain_eff = lcr_pkg::GAIN_MIN;
        end else if (r_gain > lcr_pkg::GAIN_MAX) begin
            gain_eff = lcr_pkg::GAIN_MAX;
        end else begin
            gain_eff = r_gain;
        end
    end

    assign bit_total  = lcr_pkg::LCR_BITCNT_W'(lcr_pkg::LCR_COUNT_BITS)
                      + lcr_pkg::LCR_BITCNT_W'(gain_eff);
    assign phase_len  = (r_pulse == '0) ? '0 : r_pulse - 1'b1;
    assign extra_wide = ((lcr_pkg::LCR_EXTRA_MAX+1)'(1) << gain_eff)
                      - (lcr_pkg::LCR_EXTRA_MAX+1)'(1);
    assign extra_mask = extra_wide[lcr_pkg::LCR_EXTRA_MAX-1:0];
    assign counts     = r_shift[gain_eff +: lcr_pkg::LCR_COUNT_BITS];
    assign counts_ext = {{(lcr_pkg::LCR_WORD_W-lcr_pkg::LCR_COUNT_BITS)
                          {counts[lcr_pkg::LCR_COUNT_BITS-1]}}, counts};
    assign cfg_poll_wr = i_cfg_we && (i_cfg_index == lcr_pkg::REG_POLL);

    always_comb begin
        n_timer    = r_timer;
        n_pending  = r_pending;
        n_ovf_flag = r_ovf_flag;
        n_bitcnt   = r_bitcnt;
        n_shift    = r_shift;
        n_ptimer   = r_ptimer;
        n_phase    = r_phase;
        n_err      = r_err;
        n_ovf_tot  = r_ovf_tot;
        timer_dec  = r_timer;
        res        = '0;
        res.data_ready = ~i_dout;

        if (r_poll == '0) begin
            res.sclk_level = 1'b1;
        end else begin
            // read sequencer
            if (r_pending) begin
                if (r_ptimer != '0) begin
                    n_ptimer = r_ptimer - 1'b1;
                end else if (r_phase) begin
                    n_phase  = 1'b0;
                    n_shift  = {r_shift[lcr_pkg::LCR_SHIFT_W-2:0], i_dout};
                    if (r_bitcnt < lcr_pkg::BITCNT_MAX) begin
                        n_bitcnt = r_bitcnt + 1'b1;
                    end
                    n_ptimer = phase_len;
                end else if (r_bitcnt >= bit_total) begin
                    if ((r_shift[lcr_pkg::LCR_EXTRA_MAX-1:0] & extra_mask) != extra_mask) begin
                        n_err = lcr_pkg::ERR_DESYNC;
                    end else if (r_ovf_flag) begin
                        n_err = lcr_pkg::ERR_TOO_LONG;
                    end
                    res.sample_valid = 1'b1;
                    case (n_err)
                        lcr_pkg::ERR_DESYNC:   res.sample_word = lcr_pkg::WORD_DESYNC;
                        lcr_pkg::ERR_TOO_LONG: res.sample_word = lcr_pkg::WORD_TOO_LONG;
                        default:               res.sample_word = counts_ext;
                    endcase
                    n_pending  = 1'b0;
                    n_ovf_flag = 1'b0;
                    n_bitcnt   = '0;
                    n_shift    = '0;
                    n_ptimer   = '0;
                    n_phase    = 1'b0;
                end else begin
                    n_phase  = 1'b1;
                    n_ptimer = phase_len;
                end
            end

            // poll timer
            if (r_timer != '0) begin
                timer_dec = r_timer - 1'b1;
            end
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                if (n_pending) begin
                    if (r_ovf_tot != lcr_pkg::OVF_SAT) begin
                        n_ovf_tot = r_ovf_tot + 1'b1;
                    end
                    n_ovf_flag = 1'b1;
                    n_timer    = {1'b0, r_poll, 2'b00};
                end else if (!i_dout) begin
                    n_pending  = 1'b1;
                    n_ovf_flag = 1'b0;
                    n_bitcnt   = '0;
                    n_shift    = '0;
                    n_ptimer   = '0;
                    n_phase    = 1'b0;
                    n_timer    = {r_poll, 3'b000};
                end else begin
                    n_timer = {3'b000, r_poll};
                end
            end
            res.sclk_level = n_phase;
        end
        res.overflow_count = n_ovf_tot;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= lcr_pkg::GAIN_RESET;
            r_poll     <= '0;
            r_pulse    <= lcr_pkg::PULSE_RESET;
            r_timer    <= '0;
            r_pending  <= 1'b0;
            r_ovf_flag <= 1'b0;
            r_bitcnt   <= '0;
            r_shift    <= '0;
            r_ptimer   <= '0;
            r_phase    <= 1'b0;
            r_err      <= lcr_pkg::ERR_NONE;
            r_ovf_tot  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcr_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data[lcr_pkg::LCR_GAIN_W-1:0];
                end
                lcr_pkg::REG_POLL: begin
                    r_poll     <= i_cfg_data[lcr_pkg::LCR_POLL_W-1:0];
                    r_timer    <= {3'b000, i_cfg_data[lcr_pkg::LCR_POLL_W-1:0]};
                    r_pending  <= 1'b0;
                    r_ovf_flag <= 1'b0;
                    r_bitcnt   <= '0;
                    r_shift    <= '0;
                    r_ptimer   <= '0;
                    r_phase    <= 1'b0;
                    r_err      <= lcr_pkg::ERR_NONE;
                    if (i_cfg_data[lcr_pkg::LCR_POLL_W-1:0] != '0) begin
                        r_ovf_tot <= '0;
                    end
                end
                lcr_pkg::REG_PULSE: begin
                    r_pulse <= i_cfg_data[lcr_pkg::LCR_PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_step) begin
            r_timer    <= n_timer;
            r_pending  <= n_pending;
            r_ovf_flag <= n_ovf_flag;
            r_bitcnt   <= n_bitcnt;
            r_shift    <= n_shift;
            r_ptimer   <= n_ptimer;
            r_phase    <= n_phase;
            r_err      <= n_err;
            r_ovf_tot  <= n_ovf_tot;
        end
    end

    a_phase_needs_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_pending)
        else $error("serial clock high with no read in progress");

    a_idle_read_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_bitcnt == '0 && r_shift == '0))
        else $error("read state not cleared while idle");

    a_ovf_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_poll_wr |=> r_ovf_tot >= $past(r_ovf_tot))
        else $error("overflow total decreased without a poll write");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg_we && res.sample_valid && r_err != lcr_pkg::ERR_NONE)
        |-> (res.sample_word == lcr_pkg::WORD_DESYNC
             || res.sample_word == lcr_pkg::WORD_TOO_LONG))
        else $error("sample emitted while an error is latched");

endmodule

// File: bench/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker
// Watches the pin-tick stream, the result stream and the register port of
// the load cell serial reader. It keeps its own copy of the reader state,
// predicts one result per accepted tick and compares each result transaction
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lcr_checker
    import lcr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [7:0]                i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [55:0]               i_m_tdata,
    input  logic                      i_cfg_we,
    input  logic [LCR_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LCR_CFG_DATA_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int PRINT_LIMIT = 40;

    logic [LCR_GAIN_W-1:0]   gain_sel;
    logic [LCR_POLL_W-1:0]   poll_ival;
    logic [LCR_PULSE_W-1:0]  pulse_len;

    logic [LCR_TIMER_W-1:0]  poll_tmr;
    logic                    rd_busy;
    logic                    ovf_seen;
    logic [LCR_BITCNT_W-1:0] bit_cnt;
    logic [LCR_SHIFT_W-1:0]  shreg;
    logic [LCR_PULSE_W-1:0]  pulse_tmr;
    logic                    sclk_hi;
    t_err                    err_state;
    logic [LCR_OVF_W-1:0]    ovf_total;

    t_result                 sample_q[$];

    function automatic logic [LCR_GAIN_W-1:0] live_gain();
        if (gain_sel < GAIN_MIN) return GAIN_MIN;
        if (gain_sel > GAIN_MAX) return GAIN_MAX;
        return gain_sel;
    endfunction

    function automatic logic [LCR_PULSE_W-1:0] half_period();
        return (pulse_len == '0) ? '0 : pulse_len - 1'b1;
    endfunction

    task automatic abort_read();
        rd_busy   = 1'b0;
        ovf_seen  = 1'b0;
        bit_cnt   = '0;
        shreg     = '0;
        pulse_tmr = '0;
        sclk_hi   = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] seen);
        if (o_fail_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s expected 0x%0h got 0x%0h",
                     $time, what, want, seen);
        o_fail_count++;
    endtask

    task automatic predict_tick(input logic dout, output t_result r);
        logic [LCR_GAIN_W-1:0]     g;
        logic [LCR_SHIFT_W-1:0]    shifted;
        logic [LCR_COUNT_BITS-1:0] count;
        logic [LCR_EXTRA_MAX:0]    tail_mask;
        r = '0;
        r.data_ready = ~dout;
        if (poll_ival == '0) begin
            r.sclk_level = 1'b1;
        end else begin
            if (rd_busy) begin
                g = live_gain();
                if (pulse_tmr != '0) begin
                    pulse_tmr = pulse_tmr - 1'b1;
                end else if (sclk_hi) begin
                    sclk_hi = 1'b0;
                    shreg   = {shreg[LCR_SHIFT_W-2:0], dout};
                    if (bit_cnt != BITCNT_MAX)
                        bit_cnt = bit_cnt + 1'b1;
                    pulse_tmr = half_period();
                end else if (bit_cnt >= LCR_COUNT_BITS + g) begin
                    tail_mask = (LCR_EXTRA_MAX+1)'((1 << g) - 1);
                    shifted   = shreg >> g;
                    count     = shifted[LCR_COUNT_BITS-1:0];
                    if ((shreg[LCR_EXTRA_MAX:0] & tail_mask) != tail_mask)
                        err_state = ERR_DESYNC;
                    else if (ovf_seen)
                        err_state = ERR_TOO_LONG;
                    case (err_state)
                        ERR_DESYNC:   r.sample_word = WORD_DESYNC;
                        ERR_TOO_LONG: r.sample_word = WORD_TOO_LONG;
                        default: begin
                            r.sample_word = {{(LCR_WORD_W-LCR_COUNT_BITS)
                                              {count[LCR_COUNT_BITS-1]}}, count};
                        end
                    endcase
                    r.sample_valid = 1'b1;
                    abort_read();
                end else begin
                    sclk_hi   = 1'b1;
                    pulse_tmr = half_period();
                end
            end
            if (poll_tmr != '0)
                poll_tmr = poll_tmr - 1'b1;
            if (poll_tmr == '0) begin
                poll_tmr = LCR_TIMER_W'(poll_ival);
                if (rd_busy) begin
                    if (ovf_total != OVF_SAT)
                        ovf_total = ovf_total + 1'b1;
                    ovf_seen = 1'b1;
                    poll_tmr = poll_tmr << 2;
                end else if (!dout) begin
                    abort_read();
                    rd_busy  = 1'b1;
                    poll_tmr = poll_tmr << 3;
                end
            end
            r.sclk_level = sclk_hi;
        end
        r.overflow_count = ovf_total;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        t_result next_res;
        if (!i_rst_n) begin
            gain_sel  = GAIN_RESET;
            poll_ival = '0;
            pulse_len = PULSE_RESET;
            poll_tmr  = '0;
            err_state = ERR_NONE;
            ovf_total = '0;
            abort_read();
            sample_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[LCR_RES_W-1:0];
                if (sample_q.size() == 0) begin
                    report_mismatch("result with no pending tick", '0, 64'(i_m_tdata));
                end else begin
                    want = sample_q.pop_front();
                    if (seen.sclk_level !== want.sclk_level)
                        report_mismatch("sclk_level", 64'(want.sclk_level),
                                        64'(seen.sclk_level));
                    if (seen.sample_valid !== want.sample_valid)
                        report_mismatch("sample_valid", 64'(want.sample_valid),
                                        64'(seen.sample_valid));
                    if (seen.sample_word !== want.sample_word)
                        report_mismatch("sample_word", 64'(want.sample_word),
                                        64'(seen.sample_word));
                    if (seen.data_ready !== want.data_ready)
                        report_mismatch("data_ready", 64'(want.data_ready),
                                        64'(seen.data_ready));
                    if (seen.overflow_count !== want.overflow_count)
                        report_mismatch("overflow_count", 64'(want.overflow_count),
                                        64'(seen.overflow_count));
                    if (i_m_tdata[55:LCR_RES_W] !== '0)
                        report_mismatch("tdata padding", '0,
                                        64'(i_m_tdata[55:LCR_RES_W]));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN:  gain_sel = i_cfg_data[LCR_GAIN_W-1:0];
                    REG_POLL: begin
                        poll_ival = i_cfg_data;
                        abort_read();
                        err_state = ERR_NONE;
                        poll_tmr  = LCR_TIMER_W'(poll_ival);
                        if (poll_ival != '0)
                            ovf_total = '0;
                    end
                    REG_PULSE: pulse_len = i_cfg_data[LCR_PULSE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tdata[0], next_res);
                sample_q.push_back(next_res);
            end
        end
        o_pending = sample_q.size();
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the load cell serial reader. Drives pin ticks as
// converter read frames (ready low, random count bits, trailing ones), broken
// frames, overrun frames and noise, under several register settings and
// handshake idling patterns. Prediction and comparison live in lcr_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lcr_pkg::*;

    localparam logic [LCR_CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 48;
    localparam int OVF_TICKS   = 32;
    localparam int NUM_PHASES  = 6;

    typedef enum logic [1:0] {
        PAT_LOW,
        PAT_HIGH,
        PAT_RAND
    } t_pattern;

    typedef enum int {
        KIND_GOOD,
        KIND_OVERRUN,
        KIND_BAD_TAIL,
        KIND_LIVE_GAIN,
        KIND_NOISE
    } t_frame_kind;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;   // [0] dout_level
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [0] sclk_level, [1] sample_valid, [33:2] sample_word, [34] data_ready,
    // [50:35] overflow_count
    logic [55:0]               m_axis_tdata;
    logic                      i_cfg_we      = 1'b0;
    logic [LCR_CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [LCR_CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    load_cell_adc_serial_reader_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lcr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        #(12 * 3_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic send_dout(input logic dout);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, dout};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_run(input int n, input t_pattern pat);
        for (int k = 0; k < n; k++) begin
            case (pat)
                PAT_LOW:  send_dout(1'b0);
                PAT_HIGH: send_dout(1'b1);
                default:  send_dout(1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [LCR_CFG_IDX_W-1:0] idx,
                             input logic [LCR_CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // ready low long enough to catch one poll, count bits, then trailing bits
    task automatic run_frame(input int p, input int pw, input logic bad_tail,
                             input logic gain_mid);
        t_pattern tail;
        tail = bad_tail ? PAT_RAND : PAT_HIGH;
        send_run(p, PAT_LOW);
        send_run(48 * pw - p, PAT_RAND);
        if (gain_mid) begin
            send_run(6 * pw, tail);
            settle();
            write_reg(REG_GAIN, 32'($urandom_range(0, 7)));
            send_run(10 * pw + p + 4, tail);
        end else begin
            send_run(16 * pw + p + 4, tail);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // powered down after reset: clock pin held high
        send_dout(1'b0);
        send_dout(1'b1);
        send_dout(1'b0);
        settle();
        write_reg(REG_UNUSED, $urandom());
        send_dout(1'b1);
        send_dout(1'b0);
        settle();
        // gain zero, zero pulse, poll every tick: read overruns at once
        write_reg(REG_GAIN, $urandom() & 32'hFFFF_FFF8);
        write_reg(REG_PULSE, $urandom() & 32'hFFFF_0000);
        write_reg(REG_POLL, 32'd1);
        send_run(2, PAT_HIGH);
        send_run(13, PAT_LOW);
        settle();
        write_reg(REG_POLL, 32'hFFFF_FFFF);
        write_reg(REG_PULSE, 32'h0000_FFFF);
        write_reg(REG_GAIN, 32'd7);
        send_run(4, PAT_LOW);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            t_frame_kind kind;
            int          pw;
            int          pulse_w;
            int          p;
            logic [LCR_GAIN_W-1:0] gsel;
            settle();
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            kind = (ph < 5) ? t_frame_kind'(ph) : t_frame_kind'($urandom_range(0, 4));
            gsel = ($urandom_range(9) < 8) ? 3'($urandom_range(1, 4))
                                           : 3'($urandom_range(0, 7));
            pw      = ($urandom_range(3) == 0) ? 2 : 1;
            pulse_w = (pw == 1 && $urandom_range(3) == 0) ? 0 : pw;
            p = (kind == KIND_OVERRUN) ? $urandom_range(1, 4 * pw)
                                       : 7 * pw + 1 + $urandom_range(0, 2);
            write_reg(REG_GAIN, ($urandom() & 32'hFFFF_FFF8) | 32'(gsel));
            write_reg(REG_PULSE, ($urandom() & 32'hFFFF_0000) | 32'(pulse_w));
            write_reg(REG_POLL, 32'(p));
            if (ph == 4)
                hold_seq++;
            case (kind)
                KIND_GOOD: begin
                    repeat (2) run_frame(p, pw, 1'b0, 1'b0);
                end
                KIND_OVERRUN:   run_frame(p, pw, 1'b0, 1'b0);
                KIND_BAD_TAIL:  run_frame(p, pw, 1'b1, 1'b0);
                KIND_LIVE_GAIN: run_frame(p, pw, 1'b0, 1'b1);
                default: begin
                    send_run(80, PAT_RAND);
                    run_frame(p, pw, 1'b0, 1'b0);
                end
            endcase
        end

        // repeated overflow, then power down keeps the count
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(REG_PULSE, 32'h0000_FFFF);
        write_reg(REG_GAIN, 32'd4);
        write_reg(REG_POLL, 32'd1);
        hold_seq++;
        send_run(OVF_TICKS, PAT_LOW);
        settle();
        write_reg(REG_POLL, 32'd0);
        send_run(6, PAT_RAND);
        settle();
        write_reg(REG_POLL, 32'd9);
        write_reg(REG_PULSE, 32'd1);
        run_frame(9, 1, 1'b0, 1'b0);

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lcr_pkg.sv
rtl/lcr_step_core.sv
rtl/load_cell_adc_serial_reader_top.sv
bench/lcr_checker.sv
bench/tb_top.sv
